FILE: hdl/dlfp_pkg.sv
// Shared types and constants for the delimited length frame parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package dlfp_pkg;

    localparam logic [7:0]  START_BYTE      = 8'h3C;  // '<'
    localparam logic [7:0]  BRACE_BYTE      = 8'h7B;  // '{'
    localparam logic [7:0]  END_BYTE        = 8'h3E;  // '>'
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd8192;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_HUNT = 3'd1,
        PH_LEN0 = 3'd2,
        PH_LEN1 = 3'd3,
        PH_DATA = 3'd4,
        PH_END  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_PAYLOAD   = 3'd0,
        KIND_OK        = 3'd1,
        KIND_BAD_START = 3'd2,
        KIND_ZERO_LEN  = 3'd3,
        KIND_TOO_LONG  = 3'd4,
        KIND_BAD_END   = 3'd5
    } kind_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] payload;
    } res_t;

endpackage

`default_nettype wire

FILE: hdl/delimited_length_frame_parser.sv
// Top level of the delimited length frame parser: stream ports, config channel.
// Depends on dlfp_pkg, dlfp_core and dlfp_obuf.
//
//  channel   dir  handshake            payload
//  s_axis    in   s_tvalid/s_tready    s_tdata[7:0]  rx_byte
//  m_axis    out  m_tvalid/m_tready    m_tdata[7:0]  payload, m_tuser[2:0] kind
//  cfg       in   cfg_valid/cfg_ready  cfg_data[15:0] max_payload
//
// One byte per cycle; each result is registered in the result buffer before it reaches m_axis.
// The two-entry result buffer sets the rate: s_tready drops only when it is full.
// cfg_ready is always high. Reset returns to waiting for '<', max_payload 8192.
`default_nettype none

module delimited_length_frame_parser
    import dlfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] payload
    output logic [2:0]       m_tuser,   // [2:0] kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    res_t  res;
    kind_t out_kind;
    logic  accept;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;   // input transaction
    assign m_tuser   = out_kind;

    dlfp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (s_tdata),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .res      (res)
    );

    dlfp_obuf u_obuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_res      (res),
        .room        (s_tready),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (out_kind),
        .out_payload (m_tdata)
    );

endmodule

`default_nettype wire

FILE: hdl/dlfp_core.sv
// Frame parser state machine: phase, length tracking and max_payload register.
// Depends on dlfp_pkg; produces at most one result per accepted byte.
`default_nettype none

module dlfp_core
    import dlfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    output res_t             res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  low_len_reg, low_len_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] max_reg;
    logic [15:0] len;
    logic [15:0] rem_dec;
    logic        is_brace;

    assign is_brace = (rx_byte == BRACE_BYTE);
    assign len      = is_brace ? {8'h00, low_len_reg} : {rx_byte, low_len_reg};
    assign rem_dec  = (rem_reg != 16'd0) ? (rem_reg - 16'd1) : rem_reg;

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        low_len_next = low_len_reg;
        rem_next     = rem_reg;
        case (phase_reg)
            PH_WAIT:
            begin
                phase_next = (rx_byte == START_BYTE) ? PH_LEN0 : PH_HUNT;
            end
            PH_HUNT:
            begin
                if (rx_byte == START_BYTE)
                begin
                    phase_next = PH_LEN0;
                end
            end
            PH_LEN0:
            begin
                low_len_next = rx_byte;
                phase_next   = PH_LEN1;
            end
            PH_LEN1:
            begin
                if (len == 16'd0 || len > max_reg)
                begin
                    phase_next = PH_HUNT;
                end
                else if (is_brace)
                begin
                    // brace is the first payload byte
                    rem_next   = len - 16'd1;
                    phase_next = (len == 16'd1) ? PH_END : PH_DATA;
                end
                else
                begin
                    rem_next   = len;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                rem_next = rem_dec;
                if (rem_dec == 16'd0)
                begin
                    phase_next = PH_END;
                end
            end
            PH_END:
            begin
                phase_next = (rx_byte == END_BYTE) ? PH_WAIT : PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // result for this byte
    always_comb
    begin
        res = '{valid: 1'b0, kind: KIND_PAYLOAD, payload: 8'h00};
        case (phase_reg)
            PH_WAIT:
            begin
                if (rx_byte != START_BYTE)
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_BAD_START;
                end
            end
            PH_LEN1:
            begin
                if (len == 16'd0)
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_ZERO_LEN;
                end
                else if (len > max_reg)
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_TOO_LONG;
                end
                else if (is_brace)
                begin
                    res.valid   = 1'b1;
                    res.payload = rx_byte;
                end
            end
            PH_DATA:
            begin
                res.valid   = 1'b1;
                res.payload = rx_byte;
            end
            PH_END:
            begin
                res.valid = 1'b1;
                res.kind  = (rx_byte == END_BYTE) ? KIND_OK : KIND_BAD_END;
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
        res.valid = res.valid & accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            low_len_reg <= 8'h00;
            rem_reg     <= 16'd0;
            max_reg     <= MAX_PAYLOAD_RST;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                low_len_reg <= low_len_next;
                rem_reg     <= rem_next;
            end
            if (cfg_we)
            begin
                max_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dlfp_obuf.sv
// Two-entry result buffer between the parser and the master stream side.
// Depends on dlfp_pkg for the result struct.
`default_nettype none

module dlfp_obuf
    import dlfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  res_t            in_res,
    output logic            room,
    output logic            out_valid,
    input  wire logic       out_ready,
    output kind_t           out_kind,
    output logic [7:0]      out_payload
);

    logic [1:0] count_reg, count_next;
    res_t       ent0_reg, ent0_next;
    res_t       ent1_reg, ent1_next;
    logic       push, pop;

    assign push        = in_res.valid;
    assign pop         = out_valid && out_ready;
    assign room        = (count_reg != 2'd2);
    assign out_valid   = (count_reg != 2'd0);
    assign out_kind    = ent0_reg.kind;
    assign out_payload = ent0_reg.payload;

    always_comb
    begin
        count_next = count_reg;
        ent0_next  = ent0_reg;
        ent1_next  = ent1_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    ent0_next  = in_res;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    ent0_next = in_res;
                end
                else if (push)
                begin
                    ent1_next  = in_res;
                    count_next = 2'd2;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    ent0_next  = ent1_reg;
                    count_next = 2'd1;
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && count_reg == 2'd2))
        else $error("result pushed into full buffer");

    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_payload))
        else $error("stalled result changed");

    a_second_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 && pop |=> out_payload == $past(ent1_reg.payload))
        else $error("second entry not moved to head");

endmodule

`default_nettype wire

FILE: sim/delimited_length_frame_parser_test.sv
// Self-checking testbench for delimited_length_frame_parser: random framed byte traffic
// with random gaps and stalls, checked against a scoreboard that tracks the frame state.
// Depends on dlfp_pkg and the delimited_length_frame_parser RTL.
`timescale 1ns / 100ps

module delimited_length_frame_parser_test;
    import dlfp_pkg::*;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } frame_result_t;

    class frame_scoreboard;
        phase_t          ph;
        logic [7:0]      len_lo;
        logic [15:0]     remaining;
        logic [15:0]     max_len;
        frame_result_t   expected_q[$];
        int              errors;

        function new();
            ph        = PH_WAIT;
            len_lo    = 8'h00;
            remaining = 16'h0000;
            max_len   = MAX_PAYLOAD_RST;
            errors    = 0;
        endfunction

        function void set_max(logic [15:0] v);
            max_len = v;
        endfunction

        function void push(kind_t k, logic [7:0] d);
            frame_result_t r;
            r.kind = k;
            r.data = d;
            expected_q = {expected_q, r};
        endfunction

        function void note_byte(logic [7:0] b);
            logic [15:0] len;
            len = 16'h0000;
            case (ph)
                PH_WAIT:
                begin
                    if (b == START_BYTE)
                        ph = PH_LEN0;
                    else
                    begin
                        ph = PH_HUNT;
                        push(KIND_BAD_START, 8'h00);
                    end
                end
                PH_HUNT:
                begin
                    if (b == START_BYTE)
                        ph = PH_LEN0;
                end
                PH_LEN0:
                begin
                    len_lo = b;
                    ph     = PH_LEN1;
                end
                PH_LEN1:
                begin
                    len = (b == BRACE_BYTE) ? {8'h00, len_lo} : {b, len_lo};
                    if (len == 16'h0000)
                    begin
                        ph = PH_HUNT;
                        push(KIND_ZERO_LEN, 8'h00);
                    end
                    else if (len > max_len)
                    begin
                        ph = PH_HUNT;
                        push(KIND_TOO_LONG, 8'h00);
                    end
                    else if (b == BRACE_BYTE)
                    begin
                        // brace byte is itself the first payload byte
                        remaining = len - 16'd1;
                        ph        = (remaining == 16'h0000) ? PH_END : PH_DATA;
                        push(KIND_PAYLOAD, b);
                    end
                    else
                    begin
                        remaining = len;
                        ph        = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (remaining > 16'h0000)
                        remaining = remaining - 16'd1;
                    if (remaining == 16'h0000)
                        ph = PH_END;
                    push(KIND_PAYLOAD, b);
                end
                PH_END:
                begin
                    if (b == END_BYTE)
                    begin
                        ph = PH_WAIT;
                        push(KIND_OK, 8'h00);
                    end
                    else
                    begin
                        // offending byte is consumed, even a start byte
                        ph = PH_HUNT;
                        push(KIND_BAD_END, 8'h00);
                    end
                end
                default:
                    ph = PH_HUNT;
            endcase
        endfunction

        function void check_result(logic [2:0] kind, logic [7:0] data);
            frame_result_t r;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result kind %0d data %02h", $time, kind, data);
                return;
            end
            r = expected_q[0];
            expected_q.delete(0);
            if (kind !== r.kind)
            begin
                errors++;
                $display("%0t: kind mismatch expected %0d actual %0d", $time, r.kind, kind);
            end
            if (data !== r.data)
            begin
                errors++;
                $display("%0t: payload mismatch expected %02h actual %02h",
                         $time, r.data, data);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    frame_scoreboard board;
    logic [15:0]     cur_max;
    bit              fast_mode;
    bit              hold_req;
    int              items_sent;

    delimited_length_frame_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] rx_byte
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] payload
        .m_tuser   (m_tuser),    // [2:0] kind
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("delimited_length_frame_parser_test failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_byte(b);
        items_sent++;
        @(negedge clk);
    endtask

    // Sender pause: no traffic until every expected result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_max(logic [15:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_max(v);
        cur_max = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_data();
        case ($urandom_range(0, 15))
            0:       return START_BYTE;
            1:       return END_BYTE;
            2:       return BRACE_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_len();
        int cap;
        if (cur_max <= 16'd300 && $urandom_range(0, 19) == 0)
            return int'(cur_max);
        if ($urandom_range(0, 39) == 0)
            cap = (cur_max < 16'd300) ? int'(cur_max) : 300;
        else
            cap = (cur_max < 16'd24) ? int'(cur_max) : 24;
        return $urandom_range(1, cap);
    endfunction

    // Header and payload of a frame of length len; closing byte is sent by the caller.
    task automatic send_body(int len);
        logic [15:0] l16;
        int          n;
        l16 = 16'(len);
        send_byte(START_BYTE);
        if (len <= 255 && $urandom_range(0, 1) == 1)
        begin
            send_byte(l16[7:0]);
            send_byte(BRACE_BYTE);
            n = len - 1;
        end
        else
        begin
            send_byte(l16[7:0]);
            send_byte(l16[15:8]);
            n = len;
        end
        repeat (n) send_byte(rand_data());
    endtask

    task automatic send_random_frame();
        int          sel;
        int          n;
        logic [7:0]  b;
        logic [15:0] l16;
        sel = $urandom_range(0, 99);
        if (sel < 60)
        begin
            send_body(pick_len());
            send_byte(END_BYTE);
        end
        else if (sel < 70)
        begin
            send_body(pick_len());
            if ($urandom_range(0, 2) == 0)
                b = START_BYTE;
            else
            begin
                b = 8'($urandom_range(0, 255));
                if (b == END_BYTE)
                    b = 8'h00;
            end
            send_byte(b);
        end
        else if (sel < 78)
        begin
            send_byte(START_BYTE);
            send_byte(8'h00);
            send_byte(($urandom_range(0, 1) == 1) ? BRACE_BYTE : 8'h00);
        end
        else if (sel < 86 && cur_max != 16'hFFFF)
        begin
            l16 = cur_max + 16'd1;
            send_byte(START_BYTE);
            send_byte(l16[7:0]);
            send_byte(l16[15:8]);
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(rand_data());
        end
    endtask

    // Receiver: random stall before each transaction, one long hold-off on request.
    initial
    begin : receiver
        int stall;
        m_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                stall    = 200;
                hold_req = 1'b0;
            end
            else
                stall = fast_mode ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            board.check_result(m_tuser, m_tdata);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic [15:0] settings [5];
        int          phase_idx;
        int          target;
        board      = new();
        cur_max    = MAX_PAYLOAD_RST;
        fast_mode  = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        cfg_valid  = 1'b0;
        cfg_data   = 16'h0000;
        settings[0] = 16'd1;
        settings[1] = 16'hFFFF;
        settings[2] = 16'd300;
        settings[3] = 16'd20;
        settings[4] = 16'($urandom_range(1, 65535));
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: bad start from waiting, dropped bytes while hunting
        send_byte(8'h78);
        send_byte(8'hFF);
        send_byte(START_BYTE); send_byte(8'h00); send_byte(BRACE_BYTE);  // zero, brace form
        send_byte(START_BYTE); send_byte(8'h01); send_byte(BRACE_BYTE);  // brace only payload
        send_byte(END_BYTE);
        send_byte(START_BYTE); send_byte(8'h02); send_byte(8'h00);       // two-byte form
        send_byte(8'hFF); send_byte(8'h00); send_byte(END_BYTE);
        send_byte(START_BYTE); send_byte(8'h01); send_byte(BRACE_BYTE);  // bad end on '<'
        send_byte(START_BYTE);
        send_byte(START_BYTE); send_byte(8'h01); send_byte(8'h20);       // 8193: too long
        send_byte(START_BYTE); send_byte(8'h00); send_byte(8'h00);       // zero, two-byte

        for (phase_idx = 0; phase_idx < 5; phase_idx++)
        begin
            write_max(settings[phase_idx]);
            fast_mode = (phase_idx == 2);
            if (phase_idx == 1 || phase_idx == 3)
                hold_req = 1'b1;
            target = items_sent + 300;
            while (items_sent < target)
                send_random_frame();
        end
        fast_mode = 1'b0;

        drain_results();
        repeat (10) @(posedge clk);
        if (board.pending() != 0)
        begin
            board.errors++;
            $display("%0t: %0d expected results never arrived", $time, board.pending());
        end
        if (board.errors == 0)
            $display("delimited_length_frame_parser_test passed");
        else
            $display("delimited_length_frame_parser_test failed");
        $finish;
    end

endmodule
